// ===== rtl/qdv_pkg.sv =====
`timescale 1ns / 1ps
package qdv_pkg;

   localparam int unsigned TIME_W      = 32;
   localparam int unsigned POS_W       = 32;
   localparam int unsigned VEL_W       = 24;
   localparam int unsigned CFG_W       = 16;
   localparam int unsigned PULSE_W     = 32;
   localparam int unsigned CSR_DATA_W  = 32;
   localparam int unsigned CSR_ADDR_W  = 3;

   // pulses * 1000 fits in 42 bits since 1000 < 2^10
   localparam int unsigned DIVIDEND_W  = PULSE_W + 10;
   localparam int unsigned DIV_STEPS   = DIVIDEND_W;
   localparam int unsigned DIV_CNT_W   = $clog2(DIV_STEPS);

   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam logic [CFG_W-1:0] WINDOW_RESET  = CFG_W'(200);
   localparam logic [CFG_W-1:0] TIMEOUT_RESET = CFG_W'(100);

   localparam logic [VEL_W-2:0] VEL_MAX = {(VEL_W-1){1'b1}};

   // pin pair is {B, A}
   localparam logic [1:0] PIN_A_BIT = 2'h1;
   localparam logic [1:0] PIN_B_BIT = 2'h2;

   // register index, taken from paddr[2]
   localparam logic REG_WINDOW  = 1'b0;
   localparam logic REG_TIMEOUT = 1'b1;

   typedef enum logic [1:0] {
      STEP_NONE = 2'd0,
      STEP_FWD  = 2'd1,
      STEP_REV  = 2'd2
   } step_type;

   typedef enum logic [1:0] {
      DIR_STOPPED = 2'd0,
      DIR_FORWARD = 2'd1,
      DIR_REVERSE = 2'd2
   } dir_type;

   typedef enum logic {
      BK_IDLE = 1'b0,
      BK_DIV  = 1'b1
   } back_state_type;

   // classified sample handed from front to back
   typedef struct packed {
      logic [TIME_W-1:0] time_ms;
      logic              changed;
      step_type          step;
   } dec_item_type;

   typedef struct packed {
      logic signed [POS_W-1:0] position;
      logic signed [VEL_W-1:0] velocity;
      dir_type                 direction;
      logic                    pins_changed;
   } result_type;

   typedef struct packed {
      logic [CFG_W-1:0] window_ms;
      logic [CFG_W-1:0] stop_timeout_ms;
   } cfg_type;

   // x4 table, forward is 00 -> 01 -> 11 -> 10 -> 00
   function automatic step_type quad_step(input logic [1:0] prev, input logic [1:0] cur);
      step_type s;
      unique case ({prev, cur})
         4'b00_01, 4'b01_11, 4'b11_10, 4'b10_00: s = STEP_FWD;
         4'b00_10, 4'b10_11, 4'b11_01, 4'b01_00: s = STEP_REV;
         default:                                s = STEP_NONE;
      endcase
      return s;
   endfunction

endpackage

// ===== rtl/qdv_front.sv =====
`timescale 1ns / 1ps
module qdv_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  logic                 pin_a,
   input  logic                 pin_b,
   input  logic [qdv_pkg::TIME_W-1:0] time_ms,
   input  logic                 q_full,
   output logic                 q_push,
   output qdv_pkg::dec_item_type q_item
);
   import qdv_pkg::*;

   logic [1:0] prev_pins_ff;
   logic [1:0] prev_pins_in;
   logic [1:0] pins;
   logic       take;

   always_comb begin
      pins = (pin_a ? PIN_A_BIT : 2'b00) | (pin_b ? PIN_B_BIT : 2'b00);
      take = push && !q_full;
      q_push = take;
      q_item.time_ms = time_ms;
      q_item.changed = (pins != prev_pins_ff);
      q_item.step    = quad_step(prev_pins_ff, pins);
      prev_pins_in   = take ? pins : prev_pins_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_pins_ff <= 2'b00;
      end else begin
         prev_pins_ff <= prev_pins_in;
      end
   end

endmodule

// ===== rtl/qdv_queue.sv =====
`timescale 1ns / 1ps
module qdv_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  qdv_pkg::dec_item_type push_item,
   output logic                  full,
   input  logic                  pop,
   output qdv_pkg::dec_item_type pop_item,
   output logic                  empty
);
   import qdv_pkg::*;

   dec_item_type        entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]     count_ff,  count_in;
   logic                do_push, do_pop;

   always_comb begin
      full    = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
      empty   = (count_ff == '0);
      do_push = push && !full;
      do_pop  = pop && !empty;
      pop_item = entry_ff[rd_ptr_ff];
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== rtl/qdv_div.sv =====
`timescale 1ns / 1ps
module qdv_div (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [qdv_pkg::DIVIDEND_W-1:0]     dividend,
   input  logic [qdv_pkg::TIME_W-1:0]         divisor,
   output logic                               done,
   output logic [qdv_pkg::DIVIDEND_W-1:0]     quotient
);
   import qdv_pkg::*;

   // restoring divider, one quotient bit a cycle; quotient shifts into dvd
   logic                   busy_ff,  busy_in;
   logic                   done_ff,  done_in;
   logic [DIV_CNT_W-1:0]   count_ff, count_in;
   logic [DIVIDEND_W-1:0]  dvd_ff,   dvd_in;
   logic [TIME_W-1:0]      rem_ff,   rem_in;
   logic [TIME_W-1:0]      dsr_ff,   dsr_in;
   logic [TIME_W:0]        rem_sh;
   logic [TIME_W:0]        diff;
   logic                   qbit;

   always_comb begin
      rem_sh = {rem_ff, dvd_ff[DIVIDEND_W-1]};
      diff   = rem_sh - {1'b0, dsr_ff};
      qbit   = (rem_sh >= {1'b0, dsr_ff});
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      dvd_in   = dvd_ff;
      rem_in   = rem_ff;
      dsr_in   = dsr_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         dvd_in   = dividend;
         rem_in   = '0;
         dsr_in   = divisor;
      end else if (busy_ff) begin
         dvd_in   = {dvd_ff[DIVIDEND_W-2:0], qbit};
         rem_in   = qbit ? diff[TIME_W-1:0] : rem_sh[TIME_W-1:0];
         count_in = count_ff + 1'b1;
         if (count_ff == DIV_CNT_W'(DIV_STEPS-1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = dvd_ff;

endmodule

// ===== rtl/qdv_back.sv =====
`timescale 1ns / 1ps
module qdv_back (
   input  logic                  clock,
   input  logic                  reset,
   input  qdv_pkg::cfg_type      cfg,
   input  qdv_pkg::dec_item_type q_item,
   input  logic                  q_empty,
   output logic                  q_pop,
   input  logic                  out_pop,
   output logic                  out_valid,
   output qdv_pkg::result_type   out_result
);
   import qdv_pkg::*;

   back_state_type          state_ff, state_in;
   logic [POS_W-1:0]        pos_ff, pos_in;
   logic signed [VEL_W-1:0] vel_ff, vel_in;
   logic [TIME_W-1:0]       last_pulse_ff, last_pulse_in;
   logic [PULSE_W-1:0]      pulses_ff, pulses_in;
   logic [TIME_W-1:0]       win_start_ff, win_start_in;
   dir_type                 dir_ff, dir_in;
   logic [TIME_W-1:0]       now_ff, now_in;
   logic                    changed_ff, changed_in;
   logic                    neg_ff, neg_in;
   logic                    out_valid_ff, out_valid_in;
   result_type              result_ff, result_in;

   logic                    take;
   logic                    emit;
   logic [PULSE_W-1:0]      pulses_inc;
   logic [TIME_W-1:0]       elapsed;
   logic                    win_end;
   logic                    div_start;
   logic [DIVIDEND_W-1:0]   dividend;
   logic                    div_done;
   logic [DIVIDEND_W-1:0]   quotient;
   logic [VEL_W-2:0]        mag;
   logic [TIME_W-1:0]       dir_now;
   logic                    out_free;

   qdv_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (elapsed),
      .done     (div_done),
      .quotient (quotient)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: if (div_start) state_in = BK_DIV;
         BK_DIV:  if (div_done)  state_in = BK_IDLE;
         default: state_in = BK_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      out_free   = !out_valid_ff || out_pop;
      take       = (state_ff == BK_IDLE) && !q_empty && out_free;
      q_pop      = take;
      pulses_inc = pulses_ff + 1'b1;
      elapsed    = q_item.time_ms - win_start_ff;
      win_end    = (elapsed >= {{(TIME_W-CFG_W){1'b0}}, cfg.window_ms});
      dividend   = ({{(DIVIDEND_W-PULSE_W){1'b0}}, pulses_inc} << 10)
                 - ({{(DIVIDEND_W-PULSE_W){1'b0}}, pulses_inc} << 4)
                 - ({{(DIVIDEND_W-PULSE_W){1'b0}}, pulses_inc} << 3);
      mag        = (|quotient[DIVIDEND_W-1:VEL_W-1]) ? VEL_MAX : quotient[VEL_W-2:0];

      pos_in        = pos_ff;
      vel_in        = vel_ff;
      last_pulse_in = last_pulse_ff;
      pulses_in     = pulses_ff;
      win_start_in  = win_start_ff;
      now_in        = now_ff;
      changed_in    = changed_ff;
      neg_in        = neg_ff;
      div_start     = 1'b0;
      emit          = 1'b0;
      dir_now       = now_ff;

      unique case (state_ff)
         BK_IDLE: begin
            if (take) begin
               now_in     = q_item.time_ms;
               changed_in = q_item.changed;
               neg_in     = (q_item.step == STEP_REV);
               dir_now    = q_item.time_ms;
               emit       = 1'b1;
               if (q_item.step != STEP_NONE) begin
                  pos_in        = (q_item.step == STEP_FWD) ? pos_ff + 1'b1 : pos_ff - 1'b1;
                  pulses_in     = pulses_inc;
                  last_pulse_in = q_item.time_ms;
                  if (win_end) begin
                     win_start_in = q_item.time_ms;
                     pulses_in    = '0;
                     if (elapsed != '0) begin
                        div_start = 1'b1;
                        emit      = 1'b0;
                     end
                  end
               end
            end
         end
         BK_DIV: begin
            if (div_done) begin
               vel_in = neg_ff ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
               emit   = 1'b1;
            end
         end
         default: ;
      endcase

      // direction follows the velocity sign; at zero it times out to stopped
      dir_in = dir_ff;
      if (vel_in > 0) begin
         dir_in = DIR_FORWARD;
      end else if (vel_in < 0) begin
         dir_in = DIR_REVERSE;
      end else if ((dir_now - last_pulse_in) >
                   {{(TIME_W-CFG_W){1'b0}}, cfg.stop_timeout_ms}) begin
         dir_in = DIR_STOPPED;
      end
      if (!emit) begin
         dir_in = dir_ff;
      end

      result_in    = result_ff;
      out_valid_in = out_valid_ff && !out_pop;
      if (emit) begin
         out_valid_in           = 1'b1;
         result_in.position     = $signed(pos_in);
         result_in.velocity     = vel_in;
         result_in.direction    = dir_in;
         result_in.pins_changed = changed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BK_IDLE;
         pos_ff        <= '0;
         vel_ff        <= '0;
         last_pulse_ff <= '0;
         pulses_ff     <= '0;
         win_start_ff  <= '0;
         dir_ff        <= DIR_STOPPED;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pos_ff        <= pos_in;
         vel_ff        <= vel_in;
         last_pulse_ff <= last_pulse_in;
         pulses_ff     <= pulses_in;
         win_start_ff  <= win_start_in;
         dir_ff        <= dir_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff     <= now_in;
      changed_ff <= changed_in;
      neg_ff     <= neg_in;
      result_ff  <= result_in;
   end

   assign out_valid  = out_valid_ff;
   assign out_result = result_ff;

   a_no_pop_in_div: assert property (@(posedge clock) disable iff (reset)
      state_ff == BK_DIV |-> !q_pop)
      else $error("queue popped while divider busy");

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      div_start |-> elapsed != '0)
      else $error("divider started with zero divisor");

   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == BK_DIV)
      else $error("divider finished outside its state");

   a_div_emits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_DIV && div_done) |=> out_valid_ff)
      else $error("window result lost");

endmodule

// ===== rtl/quadrature_decoder_velocity.sv =====
`timescale 1ns / 1ps
// x4 quadrature decoder with position, windowed velocity and direction.
//
// Input queue: req_push / req_full, one beat per A/B pin sample with its ms
// timestamp. Result queue: rsp_empty / rsp_pop, one beat per sample, oldest
// first, holding position, velocity, direction and a pins-changed flag.
// Config over APB at csr_*: 0x0 window_ms, 0x4 stop_timeout_ms (low 16 bits);
// write only while idle.
//
// A sample that does not close a velocity window passes through the queue
// entry and the result register. A sample that closes a window first runs
// the serial restoring divider (pulses*1000 / elapsed ms, one quotient bit
// a cycle, 42 bits). Front decode accepts one beat a cycle into a 2-entry
// queue while it is not full. The back end takes one item at a time, so
// throughput is 1 item per cycle while results are popped, none while dividing.
//
// Reset (synchronous) clears position, velocity, window, direction (stopped)
// and sets window_ms = 200, stop_timeout_ms = 100. If the receiver stalls,
// the result register holds, the back end stops, the queue fills and
// req_full rises; nothing is dropped.
module quadrature_decoder_velocity (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_push,
   output logic                                   req_full,
   input  logic                                   req_pin_a,
   input  logic                                   req_pin_b,
   input  logic [qdv_pkg::TIME_W-1:0]             req_time_ms,
   output logic                                   rsp_empty,
   input  logic                                   rsp_pop,
   output logic signed [qdv_pkg::POS_W-1:0]       rsp_position,
   output logic signed [qdv_pkg::VEL_W-1:0]       rsp_velocity,
   output logic [1:0]                             rsp_direction,
   output logic                                   rsp_pins_changed,
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [qdv_pkg::CSR_ADDR_W-1:0]         csr_paddr,
   input  logic [qdv_pkg::CSR_DATA_W-1:0]         csr_pwdata,
   output logic [qdv_pkg::CSR_DATA_W-1:0]         csr_prdata,
   output logic                                   csr_pready
);
   import qdv_pkg::*;

   cfg_type      cfg_ff, cfg_in;
   logic         csr_wr;
   logic         reg_sel;

   dec_item_type f_item;
   logic         f_push;
   logic         q_full;
   dec_item_type q_item;
   logic         q_empty;
   logic         q_pop;
   logic         out_valid;
   result_type   out_result;

   // config registers; the word index is paddr[2]
   always_comb begin
      csr_pready = 1'b1;
      reg_sel    = csr_paddr[2];
      csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
      cfg_in     = cfg_ff;
      if (csr_wr) begin
         case (reg_sel)
            REG_WINDOW:  cfg_in.window_ms       = csr_pwdata[CFG_W-1:0];
            REG_TIMEOUT: cfg_in.stop_timeout_ms = csr_pwdata[CFG_W-1:0];
            default: ;
         endcase
      end
      case (reg_sel)
         REG_WINDOW:  csr_prdata = {{(CSR_DATA_W-CFG_W){1'b0}}, cfg_ff.window_ms};
         REG_TIMEOUT: csr_prdata = {{(CSR_DATA_W-CFG_W){1'b0}}, cfg_ff.stop_timeout_ms};
         default:     csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_ms       <= WINDOW_RESET;
         cfg_ff.stop_timeout_ms <= TIMEOUT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: pin decode and step classification
   qdv_front u_front (
      .clock   (clock),
      .reset   (reset),
      .push    (req_push),
      .pin_a   (req_pin_a),
      .pin_b   (req_pin_b),
      .time_ms (req_time_ms),
      .q_full  (q_full),
      .q_push  (f_push),
      .q_item  (f_item)
   );

   assign req_full = q_full;

   // decouples decode from the position/velocity back end
   qdv_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (f_push),
      .push_item (f_item),
      .full      (q_full),
      .pop       (q_pop),
      .pop_item  (q_item),
      .empty     (q_empty)
   );

   // back: position, window, divider, direction, result register
   qdv_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_item     (q_item),
      .q_empty    (q_empty),
      .q_pop      (q_pop),
      .out_pop    (rsp_pop),
      .out_valid  (out_valid),
      .out_result (out_result)
   );

   assign rsp_empty        = !out_valid;
   assign rsp_position     = out_result.position;
   assign rsp_velocity     = out_result.velocity;
   assign rsp_direction    = out_result.direction;
   assign rsp_pins_changed = out_result.pins_changed;

endmodule
